@@ rtl/lst_pkg.sv @@
// Shared types and constants for the lifecycle slot table.
package lst_pkg;
	localparam int unsigned SLOTS = 16;
	localparam int unsigned IW = 4;

	typedef enum logic [3:0] {
		CMD_RESERVE = 4'd0, CMD_ACCEPT = 4'd1, CMD_TERMINAL = 4'd2, CMD_FAILED = 4'd3,
		CMD_RELEASE = 4'd4, CMD_INSPECT = 4'd5, CMD_EVENT = 4'd6, CMD_COUNTS = 4'd7,
		CMD_STATUS = 4'd8
	} cmd_t;

	localparam logic [2:0] RC_OK = 3'd0;
	localparam logic [2:0] RC_TERMINAL = 3'd1;
	localparam logic [2:0] RC_EXHAUSTED = 3'd2;
	localparam logic [2:0] RC_INVALID_OP = 3'd3;
	localparam logic [2:0] RC_INVALID_RES = 3'd4;
	localparam logic [2:0] RC_DUPLICATE = 3'd5;
	localparam logic [2:0] RC_NOT_FOUND = 3'd6;

	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_RESERVED = 2'd1;
	localparam logic [1:0] PH_VISIBLE = 2'd2;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_FAILED = 3'd2;

	typedef struct packed {
		logic [1:0] phase;
		logic [31:0] generation;
		logic [31:0] operation;
		logic [2:0] op_state;
		logic [31:0] revision;
		logic ev_visible;
		logic [31:0] ev_id;
		logic ev_failed;
	} slot_t;
endpackage

@@ rtl/lifecycle_slot_table_unit.sv @@
// Top level of the lifecycle slot table: sequencer, slot registers and result register.
// A command that needs no scan goes straight to execution; otherwise the scan runs first over
// cap slots, cap being the slots in use, one slot a cycle through a shared compare.
// One command at a time: in_stall is high from acceptance until the result is taken, so
// a new request is not taken until the result of the one before it has been taken.
// Reset (arst_n low, asynchronous) empties all slots, sets the generation counter to one,
// clears the other counters and the status snapshot, and sets slots in use to 16.
module lifecycle_slot_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [31:0] operation_id,
	input  logic [3:0]  slot_index,
	input  logic [31:0] token_generation,
	input  logic [2:0]  commit_state,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_code,
	output logic [3:0]  out_slot,
	output logic [31:0] out_generation,
	output logic [31:0] out_operation,
	output logic [2:0]  out_state,
	output logic [31:0] out_revision,
	output logic [31:0] out_event_id,
	output logic        out_failed,
	output logic        out_found,
	output logic [4:0]  reserved_count,
	output logic [4:0]  visible_count,
	output logic [31:0] event_count
);
	import lst_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	slot_t slot_q [SLOTS];
	logic [4:0] cap_q, cfg_q, idx_q, r_q, v_q;
	logic [3:0] cmd_q, si_q, hit_q;
	logic [31:0] op_q, tg_q, gen_q, rev_q, eid_q, evt_q, lso_q, lsr_q;
	logic [2:0] ts_q, lss_q;
	logic found_q;

	logic [3:0] ix;
	slot_t cur;
	logic [4:0] cap_in;
	logic match;
	logic [31:0] nrev;

	assign ix = idx_q[IW-1:0];
	assign cur = slot_q[ix];
	assign cap_in = (cfg_q > 5'(SLOTS)) ? 5'(SLOTS) : cfg_q;
	assign nrev = rev_q + 32'd1;

	always_comb begin
		unique case (cmd_t'(cmd_q))
			CMD_RESERVE: match = (cur.phase == PH_EMPTY);
			CMD_EVENT:   match = cur.ev_visible &&
				(!found_q || cur.revision > slot_q[hit_q].revision);
			default:     match = (cur.phase == PH_VISIBLE) && (cur.operation == op_q);
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q <= 5'd16;
			gen_q <= 32'd1;
			rev_q <= '0;
			eid_q <= '0;
			evt_q <= '0;
			lso_q <= '0;
			lss_q <= '0;
			lsr_q <= '0;
			for (int k = 0; k < SLOTS; k++) slot_q[k] <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command; op_q <= operation_id; si_q <= slot_index;
						tg_q <= token_generation; ts_q <= commit_state;
						cap_q <= cap_in; idx_q <= '0; found_q <= 1'b0; hit_q <= '0;
						r_q <= '0; v_q <= '0;
						result_code <= RC_OK; out_slot <= '0; out_generation <= '0;
						out_operation <= '0; out_state <= '0; out_revision <= '0;
						out_event_id <= '0; out_failed <= 1'b0; out_found <= 1'b0;
						reserved_count <= '0; visible_count <= '0; event_count <= '0;
						state_q <= (command <= 4'(CMD_COUNTS)) ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					if (idx_q >= cap_q) begin
						state_q <= S_EXEC;
					end else begin
						if (cur.phase == PH_RESERVED) r_q <= r_q + 5'd1;
						if (cur.phase == PH_VISIBLE) v_q <= v_q + 5'd1;
						if (match && (!found_q || cmd_q == 4'(CMD_EVENT))) begin
							found_q <= 1'b1; hit_q <= ix;
						end
						idx_q <= idx_q + 5'd1;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					unique case (cmd_q)
						4'(CMD_RESERVE): begin
							if (!found_q) result_code <= RC_EXHAUSTED;
							else begin
								slot_q[hit_q].phase <= PH_RESERVED;
								slot_q[hit_q].generation <= gen_q;
								gen_q <= gen_q + 32'd1;
								out_slot <= hit_q; out_generation <= gen_q;
							end
						end
						4'(CMD_ACCEPT): begin
							if (op_q == '0) result_code <= RC_INVALID_OP;
							else if (tg_q == '0 || {1'b0, si_q} >= cap_q)
								result_code <= RC_INVALID_RES;
							else if (found_q) result_code <= RC_DUPLICATE;
							else if (slot_q[si_q].phase != PH_RESERVED ||
								slot_q[si_q].generation != tg_q)
								result_code <= RC_INVALID_RES;
							else begin
								rev_q <= nrev;
								slot_q[si_q].phase <= PH_VISIBLE;
								slot_q[si_q].operation <= op_q;
								slot_q[si_q].op_state <= ST_ACCEPTED;
								slot_q[si_q].revision <= nrev;
								out_operation <= op_q; out_revision <= nrev;
							end
						end
						4'(CMD_TERMINAL), 4'(CMD_FAILED): begin
							if (!found_q) result_code <= RC_NOT_FOUND;
							else if (slot_q[hit_q].op_state != ST_ACCEPTED) begin
								result_code <= RC_TERMINAL;
								out_operation <= op_q;
								out_state <= slot_q[hit_q].op_state;
								out_revision <= slot_q[hit_q].revision;
							end else if (cmd_q == 4'(CMD_TERMINAL) && ts_q == ST_ACCEPTED)
								result_code <= RC_INVALID_OP;
							else begin
								rev_q <= nrev;
								slot_q[hit_q].op_state <=
									(cmd_q == 4'(CMD_FAILED)) ? ST_FAILED : ts_q;
								slot_q[hit_q].revision <= nrev;
								slot_q[hit_q].ev_visible <= 1'b1;
								slot_q[hit_q].ev_id <= eid_q;
								slot_q[hit_q].ev_failed <= (cmd_q == 4'(CMD_FAILED));
								lso_q <= op_q;
								lss_q <= (cmd_q == 4'(CMD_FAILED)) ? ST_FAILED : ts_q;
								lsr_q <= nrev;
								eid_q <= eid_q + 32'd1;
								evt_q <= evt_q + 32'd1;
								out_operation <= op_q;
								out_state <= (cmd_q == 4'(CMD_FAILED)) ? ST_FAILED : ts_q;
								out_revision <= nrev;
								out_event_id <= eid_q;
								out_failed <= (cmd_q == 4'(CMD_FAILED));
							end
						end
						4'(CMD_RELEASE): begin
							if (tg_q != '0 && {1'b0, si_q} < cap_q &&
								slot_q[si_q].phase == PH_RESERVED &&
								slot_q[si_q].generation == tg_q)
								slot_q[si_q] <= '0;
							else result_code <= RC_INVALID_RES;
						end
						4'(CMD_INSPECT), 4'(CMD_EVENT): begin
							if (found_q) begin
								out_operation <= slot_q[hit_q].operation;
								out_state <= slot_q[hit_q].op_state;
								out_revision <= slot_q[hit_q].revision;
								out_found <= 1'b1;
								if (cmd_q == 4'(CMD_EVENT)) begin
									out_event_id <= slot_q[hit_q].ev_id;
									out_failed <= slot_q[hit_q].ev_failed;
								end
							end
						end
						4'(CMD_COUNTS): begin
							out_revision <= rev_q;
							reserved_count <= r_q; visible_count <= v_q;
							event_count <= evt_q;
						end
						4'(CMD_STATUS): begin
							out_operation <= lso_q; out_state <= lss_q; out_revision <= lsr_q;
						end
						default: result_code <= RC_INVALID_OP;
					endcase
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
